>>> sv/cdq_pkg.sv
// Shared types and constants for the circular deque block.
`default_nettype none

package cdq_pkg;

	// Defaults for the top-level parameters
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed widths of the word fields
	localparam int OP_W  = 3;
	localparam int VAL_W = 32;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_OBSERVE    = 3'd4
	} cdq_op_t;

	// Per-cycle command broadcast to every cell.
	// f_* acts on the front-anchored row, b_* on the back-anchored row.
	typedef struct packed {
		logic f_shr;	// shift toward higher index, insert at cell 0
		logic f_shl;	// shift toward cell 0
		logic f_wr;	// write the cell whose index equals the count
		logic b_shr;
		logic b_shl;
		logic b_wr;
	} cdq_cmd_t;

endpackage : cdq_pkg

`default_nettype wire

>>> sv/circular_deque_top.sv
// Top level of the double-ended queue built from a chain of cells.
//
// Input channel: in_valid / in_stall carry one operation word (operation,
// data_in). Codes: push front, push back, pop front, pop back, observe.
// Output channel: out_valid / out_stall carry one result word per input
// word: accepted, front_value, back_value, is_empty, is_full, all taken
// after the operation. front_value and back_value read as -1 when empty.
// The result is registered: it is valid in the cycle after its word is
// taken. Throughput is one word per cycle while no result is held; every
// cell updates at once because each one only looks at its two neighbors,
// the new word and a broadcast command and count.
// The deque is kept twice: a row with the front element in cell 0 and a
// row with the back element in cell 0, so both ends are always at fixed
// cells. A push at one end shifts that end's row and appends to the other.
// While a result is held by out_stall, in_stall is raised and nothing moves.
// Reset (arst_n low) empties the deque and drops any pending result; the
// cell contents are not cleared and are never shown while empty.
`default_nettype none

module circular_deque_top
	import cdq_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [OP_W-1:0]         operation,
	input  wire logic signed [VAL_W-1:0] data_in,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         accepted,
	output logic signed [VAL_W-1:0]      front_value,
	output logic signed [VAL_W-1:0]      back_value,
	output logic                         is_empty,
	output logic                         is_full
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	cdq_cmd_t              cmd;
	logic [CNT_W-1:0]      count;
	logic [DATA_WIDTH-1:0] din;
	logic [DATA_WIDTH-1:0] f_q [CAPACITY];
	logic [DATA_WIDTH-1:0] b_q [CAPACITY];
	logic [VAL_W-1:0]      front_ext;
	logic [VAL_W-1:0]      back_ext;

	// Fit the word to the stored width
	generate
		if (DATA_WIDTH <= VAL_W) begin : g_din_trunc
			assign din = data_in[DATA_WIDTH-1:0];
		end else begin : g_din_zext
			assign din = {{(DATA_WIDTH - VAL_W){1'b0}}, data_in};
		end
	endgenerate

	// Control
	cdq_ctrl #(
		.CAPACITY(CAPACITY),
		.CNT_W   (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.count    (count),
		.accepted (accepted),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

	// Cell chain; cell 0 takes the new word on a shift-in
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] f_lo, f_hi, b_lo, b_hi;

			if (i == 0) begin : g_first
				assign f_lo = din;
				assign b_lo = din;
			end else begin : g_mid_lo
				assign f_lo = f_q[i-1];
				assign b_lo = b_q[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign f_hi = '0;
				assign b_hi = '0;
			end else begin : g_mid_hi
				assign f_hi = f_q[i+1];
				assign b_hi = b_q[i+1];
			end

			cdq_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.CNT_W     (CNT_W),
				.INDEX     (i)
			) u_cell (
				.clk  (clk),
				.cmd  (cmd),
				.count(count),
				.din  (din),
				.f_lo (f_lo),
				.f_hi (f_hi),
				.b_lo (b_lo),
				.b_hi (b_hi),
				.f_q  (f_q[i]),
				.b_q  (b_q[i])
			);
		end
	endgenerate

	// Sign-extend or truncate the end elements to the result width
	generate
		if (DATA_WIDTH >= VAL_W) begin : g_out_trunc
			assign front_ext = f_q[0][VAL_W-1:0];
			assign back_ext  = b_q[0][VAL_W-1:0];
		end else begin : g_out_sext
			assign front_ext = {{(VAL_W - DATA_WIDTH){f_q[0][DATA_WIDTH-1]}}, f_q[0]};
			assign back_ext  = {{(VAL_W - DATA_WIDTH){b_q[0][DATA_WIDTH-1]}}, b_q[0]};
		end
	endgenerate

	// Empty deque reads as all ones
	assign front_value = is_empty ? '1 : front_ext;
	assign back_value  = is_empty ? '1 : back_ext;

endmodule : circular_deque_top

`default_nettype wire

>>> sv/cdq_cell.sv
// One deque cell: a slot of the front-anchored row and a slot of the back-anchored row.
`default_nettype none

module cdq_cell
	import cdq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_W      = 5,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire cdq_cmd_t              cmd,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [DATA_WIDTH-1:0] din,
	input  wire logic [DATA_WIDTH-1:0] f_lo,	// front row, neighbor at INDEX-1
	input  wire logic [DATA_WIDTH-1:0] f_hi,	// front row, neighbor at INDEX+1
	input  wire logic [DATA_WIDTH-1:0] b_lo,
	input  wire logic [DATA_WIDTH-1:0] b_hi,
	output logic      [DATA_WIDTH-1:0] f_q,
	output logic      [DATA_WIDTH-1:0] b_q
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic at_end;

	assign at_end = (count == MY_IDX);

	// Front row: shift or append at the current end
	always_ff @(posedge clk) begin
		if (cmd.f_shr) begin
			f_q <= f_lo;
		end else if (cmd.f_shl) begin
			f_q <= f_hi;
		end else if (cmd.f_wr && at_end) begin
			f_q <= din;
		end
	end

	// Back row: mirror image of the front row
	always_ff @(posedge clk) begin
		if (cmd.b_shr) begin
			b_q <= b_lo;
		end else if (cmd.b_shl) begin
			b_q <= b_hi;
		end else if (cmd.b_wr && at_end) begin
			b_q <= din;
		end
	end

endmodule : cdq_cell

`default_nettype wire

>>> sv/cdq_ctrl.sv
// Operation decode, element count and handshake control for the deque.
`default_nettype none

module cdq_ctrl
	import cdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [OP_W-1:0]  operation,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output cdq_cmd_t              cmd,
	output logic      [CNT_W-1:0] count,
	output logic                  accepted,
	output logic                  is_empty,
	output logic                  is_full
);

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic             take;
	logic             ok;
	logic             is_push;
	logic             is_pop;
	logic             empty_now;
	logic             full_now;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             out_valid_q;
	logic             accepted_q;
	cdq_cmd_t         cmd_raw;

	// A new word enters once the previous result is gone or leaves now
	assign in_stall  = out_valid_q && out_stall;
	assign take      = in_valid && !in_stall;
	assign empty_now = (cnt_q == '0);
	assign full_now  = (cnt_q == CAP_C);

	// Decode: row commands and next count for the presented word
	always_comb begin
		cmd_raw = '0;
		ok      = 1'b0;
		is_push = 1'b0;
		is_pop  = 1'b0;
		case (cdq_op_t'(operation))
			OP_PUSH_FRONT: begin
				is_push = 1'b1;
				if (!full_now) begin
					ok            = 1'b1;
					cmd_raw.f_shr = 1'b1;
					cmd_raw.b_wr  = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				is_push = 1'b1;
				if (!full_now) begin
					ok            = 1'b1;
					cmd_raw.b_shr = 1'b1;
					cmd_raw.f_wr  = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				is_pop = 1'b1;
				if (!empty_now) begin
					ok            = 1'b1;
					cmd_raw.f_shl = 1'b1;
				end
			end
			OP_POP_BACK: begin
				is_pop = 1'b1;
				if (!empty_now) begin
					ok            = 1'b1;
					cmd_raw.b_shl = 1'b1;
				end
			end
			OP_OBSERVE: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (take && ok && is_push) begin
			cnt_d = cnt_q + 1'b1;
		end else if (take && ok && is_pop) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	assign cmd = take ? cmd_raw : '0;

	// Count and result handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (take) begin
				out_valid_q <= 1'b1;
				accepted_q  <= ok;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign count     = cnt_q;
	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign is_empty  = empty_now;
	assign is_full   = full_now;

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("deque count above capacity");

	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		take && ok && is_push |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("accepted push did not grow the count");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		take && ok && is_pop |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("accepted pop did not shrink the count");

	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		take && !ok |=> $stable(cnt_q))
		else $error("dropped word changed the count");

	a_result_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q && accepted_q == $past(ok))
		else $error("result flag lost after a taken word");

endmodule : cdq_ctrl

`default_nettype wire
